[rtl/tpt_pkg.sv]
// Package for the page translation block: field widths, defaults and shared types.
// Used by every module in rtl; depends on nothing else.
package tpt_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned PHYS_W = 15;
  localparam int unsigned FETCH_W = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned OUT_FIELDS_W = PHYS_W + 2 + FETCH_W + 2 * COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned FRAME_COUNT_DEF = 128;
  localparam int unsigned OFFSET_BITS_DEF = 8;

  typedef enum logic [1:0] {
    ST_LOOKUP,
    ST_CHECK,
    ST_RESOLVE,
    ST_CLEAR
  } back_state_t;

  typedef struct packed {
    logic refill;
    logic drop;
  } tlb_cmd_t;

endpackage

[rtl/tpt_front.sv]
// Front end: accepts address words, splits them into page and offset, and queues them.
// Depends on tpt_pkg.
module tpt_front #(
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  logic [tpt_pkg::ADDR_W-1:0]                   s_axis_tdata,
  output logic                                         q_valid,
  output logic [tpt_pkg::ADDR_W-OFFSET_BITS-1:0]       q_page,
  output logic [OFFSET_BITS-1:0]                       q_offset,
  input  logic                                         q_pop
);

  localparam int unsigned PAGE_W = tpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned PTR_W = $clog2(tpt_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(tpt_pkg::QUEUE_DEPTH + 1);

  logic [PAGE_W-1:0]      page_q   [tpt_pkg::QUEUE_DEPTH];
  logic [OFFSET_BITS-1:0] offset_q [tpt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   push;

  assign s_axis_tready = (count != CNT_W'(tpt_pkg::QUEUE_DEPTH));
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid = (count != '0);
  assign q_page = page_q[rd_ptr];
  assign q_offset = offset_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      page_q[wr_ptr] <= s_axis_tdata[tpt_pkg::ADDR_W-1:OFFSET_BITS];
      offset_q[wr_ptr] <= s_axis_tdata[OFFSET_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tpt_tlb.sv]
// TLB: fully associative tag compare, FIFO refill and invalidation of an evicted page.
// Depends on tpt_pkg.
module tpt_tlb #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_W = tpt_pkg::ADDR_W - tpt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned FRAME_W = $clog2(tpt_pkg::FRAME_COUNT_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [PAGE_W-1:0]  lookup_page,
  output logic               hit,
  output logic [FRAME_W-1:0] hit_frame,
  input  tpt_pkg::tlb_cmd_t  cmd,
  input  logic [PAGE_W-1:0]  refill_page,
  input  logic [FRAME_W-1:0] refill_frame,
  input  logic [PAGE_W-1:0]  drop_page
);

  localparam int unsigned SLOT_W = $clog2(TLB_ENTRIES);

  logic [PAGE_W-1:0]      tags   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frames [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;
  logic [SLOT_W-1:0]      fifo_ptr;

  // The lowest matching entry wins.
  always_comb begin
    hit = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && tags[i] == lookup_page) begin
        hit = 1'b1;
        hit_frame = frames[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.refill) begin
      tags[fifo_ptr] <= refill_page;
      frames[fifo_ptr] <= refill_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fifo_ptr <= '0;
    end else begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (cmd.drop && tags[i] == drop_page) begin
          valid[i] <= 1'b0;
        end
      end
      if (cmd.refill) begin
        valid[fifo_ptr] <= 1'b1;
        fifo_ptr <= (fifo_ptr == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : fifo_ptr + 1'b1;
      end
    end
  end

endmodule

[rtl/tpt_back.sv]
// Back end: page-to-frame map and frame owner memories, FIFO frame replacement, counters
// and the result register. Depends on tpt_pkg; drives the TLB commands.
module tpt_back #(
  parameter int unsigned FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  logic [tpt_pkg::ADDR_W-OFFSET_BITS-1:0] q_page,
  input  logic [OFFSET_BITS-1:0]                 q_offset,
  output logic                                   q_pop,
  input  logic                                   tlb_found,
  input  logic [$clog2(FRAME_COUNT)-1:0]         tlb_frame,
  output tpt_pkg::tlb_cmd_t                      tlb_cmd,
  output logic [$clog2(FRAME_COUNT)-1:0]         refill_frame,
  output logic [tpt_pkg::ADDR_W-OFFSET_BITS-1:0] drop_page,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tpt_pkg::PHYS_W-1:0]             physical_address,
  output logic                                   tlb_hit,
  output logic                                   page_fault,
  output logic [tpt_pkg::FETCH_W-1:0]            fetch_page,
  output logic [tpt_pkg::COUNT_W-1:0]            hits_so_far,
  output logic [tpt_pkg::COUNT_W-1:0]            faults_so_far
);

  localparam int unsigned PAGE_W = tpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned PAGES = 2 ** PAGE_W;

  logic [FRAME_W-1:0] page_to_frame [PAGES];
  logic [PAGE_W-1:0]  frame_owner   [FRAME_COUNT];

  tpt_pkg::back_state_t state;
  tpt_pkg::back_state_t state_next;

  logic [FRAME_W-1:0]         map_frame;
  logic [PAGE_W-1:0]          map_owner;
  logic [PAGE_W-1:0]          victim_owner;
  logic [FRAME_W-1:0]         frame_ptr;
  logic                       wrapped;
  logic [PAGE_W-1:0]          clr_idx;
  logic [tpt_pkg::COUNT_W-1:0] hit_counter;
  logic [tpt_pkg::COUNT_W-1:0] fault_counter;

  logic               out_free;
  logic               map_ok;
  logic               map_found;
  logic               finish;
  logic               hit_done;
  logic               fault_now;
  logic [FRAME_W-1:0] res_frame;
  logic [FRAME_W+OFFSET_BITS+tpt_pkg::PHYS_W-1:0] phys_wide;
  logic [PAGE_W+tpt_pkg::FETCH_W-1:0]             fetch_wide;

  assign out_free = !out_valid || out_ready;

  // A map entry counts only if its frame has been handed out and still names this page.
  assign map_ok = ({1'b0, map_frame} < (FRAME_W + 1)'(FRAME_COUNT)) &&
                  (wrapped || map_frame < frame_ptr);
  assign map_found = map_ok && (map_owner == q_page);

  always_comb begin
    state_next = state;
    finish = 1'b0;
    hit_done = 1'b0;
    fault_now = 1'b0;
    case (state)
      tpt_pkg::ST_CLEAR: begin
        if (clr_idx == PAGE_W'(PAGES - 1)) begin
          state_next = tpt_pkg::ST_LOOKUP;
        end
      end
      tpt_pkg::ST_LOOKUP: begin
        if (q_valid) begin
          if (tlb_found) begin
            if (out_free) begin
              finish = 1'b1;
              hit_done = 1'b1;
            end
          end else begin
            state_next = tpt_pkg::ST_CHECK;
          end
        end
      end
      tpt_pkg::ST_CHECK: begin
        state_next = tpt_pkg::ST_RESOLVE;
      end
      tpt_pkg::ST_RESOLVE: begin
        fault_now = !map_found;
        if (out_free) begin
          finish = 1'b1;
          state_next = tpt_pkg::ST_LOOKUP;
        end
      end
      default: begin
        state_next = tpt_pkg::ST_LOOKUP;
      end
    endcase
  end

  assign q_pop = finish;
  assign tlb_cmd.refill = finish && !hit_done;
  assign tlb_cmd.drop = finish && fault_now && wrapped;
  assign refill_frame = fault_now ? frame_ptr : map_frame;
  assign drop_page = victim_owner;
  assign res_frame = hit_done ? tlb_frame : refill_frame;
  assign phys_wide = {{tpt_pkg::PHYS_W{1'b0}}, res_frame, q_offset};
  assign fetch_wide = {{tpt_pkg::FETCH_W{1'b0}}, q_page};

  always_ff @(posedge clk) begin
    map_frame <= page_to_frame[q_page];
    map_owner <= frame_owner[map_frame];
    victim_owner <= frame_owner[frame_ptr];
    if (state == tpt_pkg::ST_CLEAR) begin
      page_to_frame[clr_idx] <= '0;
    end else if (finish && fault_now) begin
      page_to_frame[q_page] <= frame_ptr;
    end
    if (finish && fault_now) begin
      frame_owner[frame_ptr] <= q_page;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      physical_address <= phys_wide[tpt_pkg::PHYS_W-1:0];
      tlb_hit <= hit_done;
      page_fault <= fault_now;
      fetch_page <= fault_now ? fetch_wide[tpt_pkg::FETCH_W-1:0] : '0;
      hits_so_far <= hit_counter + tpt_pkg::COUNT_W'(hit_done);
      faults_so_far <= fault_counter + tpt_pkg::COUNT_W'(fault_now);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpt_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == tpt_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      frame_ptr <= '0;
      wrapped <= 1'b0;
      hit_counter <= '0;
      fault_counter <= '0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (finish && hit_done) begin
        hit_counter <= hit_counter + 1'b1;
      end
      if (finish && fault_now) begin
        fault_counter <= fault_counter + 1'b1;
        if (frame_ptr == FRAME_W'(FRAME_COUNT - 1)) begin
          frame_ptr <= '0;
          wrapped <= 1'b1;
        end else begin
          frame_ptr <= frame_ptr + 1'b1;
        end
      end
    end
  end

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("item retired from an empty queue");

  a_check_then_resolve: assert property (@(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_CHECK) |=> (state == tpt_pkg::ST_RESOLVE))
    else $error("frame map check did not move on to resolve");

  a_pop_gives_word: assert property (@(posedge clk) disable iff (rst) q_pop |=> out_valid)
    else $error("retired item left no result word");

  a_fault_counts: assert property (@(posedge clk) disable iff (rst)
    (finish && fault_now) |=> (fault_counter == $past(fault_counter) + 1'b1))
    else $error("fault counter missed a fault");

endmodule

[rtl/tlb_page_translation_fifo_core.sv]
// Top level of the page translation block with TLB and FIFO frame replacement.
// Instantiates tpt_front, tpt_tlb and tpt_back; depends on tpt_pkg.
//
//   port group     dir   payload
//   s_axis_*       in    logical address words, 16 bits
//   m_axis_*       out   translation result words, 96 bits
//
// A TLB hit is resolved in the lookup state and its result word is registered; a miss
// goes on through the check and resolve states, set by the map read followed by the
// dependent frame owner read. The two-entry queue holds the word under translation
// and one more, so the front accepts while the back end or m_axis_tready stalls
// until both entries are taken. Reset is synchronous and clears the TLB valid bits,
// pointers and counters; the back end then zeroes all 256 page-to-frame map entries
// before it takes the first word.
module tlb_page_translation_fifo_core #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] logical_address
  input  logic [tpt_pkg::ADDR_W-1:0]        s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [14:0] physical_address, [15] tlb_hit, [16] page_fault, [24:17] fetch_page,
  // [56:25] hits_so_far, [88:57] faults_so_far, rest zero
  output logic [tpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned PAGE_W = tpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned PAD_W = tpt_pkg::OUT_DATA_W - tpt_pkg::OUT_FIELDS_W;

  logic                        q_valid;
  logic [PAGE_W-1:0]           q_page;
  logic [OFFSET_BITS-1:0]      q_offset;
  logic                        q_pop;
  logic                        tlb_found;
  logic [FRAME_W-1:0]          tlb_frame;
  tpt_pkg::tlb_cmd_t           tlb_cmd;
  logic [FRAME_W-1:0]          refill_frame;
  logic [PAGE_W-1:0]           drop_page;
  logic [tpt_pkg::PHYS_W-1:0]  physical_address;
  logic                        tlb_hit;
  logic                        page_fault;
  logic [tpt_pkg::FETCH_W-1:0] fetch_page;
  logic [tpt_pkg::COUNT_W-1:0] hits_so_far;
  logic [tpt_pkg::COUNT_W-1:0] faults_so_far;

  tpt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_valid      (q_valid),
    .q_page       (q_page),
    .q_offset     (q_offset),
    .q_pop        (q_pop)
  );

  tpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_W     (PAGE_W),
    .FRAME_W    (FRAME_W)
  ) u_tlb (
    .clk         (clk),
    .rst         (rst),
    .lookup_page (q_page),
    .hit         (tlb_found),
    .hit_frame   (tlb_frame),
    .cmd         (tlb_cmd),
    .refill_page (q_page),
    .refill_frame(refill_frame),
    .drop_page   (drop_page)
  );

  tpt_back #(
    .FRAME_COUNT(FRAME_COUNT),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_page          (q_page),
    .q_offset        (q_offset),
    .q_pop           (q_pop),
    .tlb_found       (tlb_found),
    .tlb_frame       (tlb_frame),
    .tlb_cmd         (tlb_cmd),
    .refill_frame    (refill_frame),
    .drop_page       (drop_page),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .physical_address(physical_address),
    .tlb_hit         (tlb_hit),
    .page_fault      (page_fault),
    .fetch_page      (fetch_page),
    .hits_so_far     (hits_so_far),
    .faults_so_far   (faults_so_far)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, faults_so_far, hits_so_far, fetch_page,
                         page_fault, tlb_hit, physical_address};

endmodule
